/* src/rsa_pkg.sv */
// Package for the reference-counted slot allocator.
// Holds the shared constants, the operation codes and the result record.
// No dependencies.
package rsa_pkg;

  localparam int SLOTS_DEF      = 1024;
  localparam int COUNT_BITS_DEF = 16;
  localparam int FIXED_W        = 10;
  localparam int SLOT_IN_W      = 10;
  localparam int COUNT_OUT_W    = 16;
  localparam int OP_W           = 2;
  localparam int WORD_BITS      = 32;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_USE     = 2'd1,
    OP_DISCARD = 2'd2,
    OP_PEEK    = 2'd3
  } op_t;

  typedef struct packed {
    logic [SLOT_IN_W-1:0]   slot_out;
    logic                   full_res;
    logic                   freed;
    logic                   ignored;
    logic [COUNT_OUT_W-1:0] use_count;
  } res_t;

endpackage

/* src/rsa_find_zero.sv */
// First-zero finder over one 32-bit word, the unit shared by the allocator core.
// Used both on the full-word summary and on occupancy words.
// Depends on rsa_pkg.
module rsa_find_zero (
  input  logic [rsa_pkg::WORD_BITS-1:0] vec,
  output logic                          found,
  output logic [4:0]                    idx
);

  logic [3:0]      byte_zero;
  logic [3:0][2:0] byte_pos;

  // Two levels: the lowest zero inside each byte, then the lowest byte that has one.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      byte_zero[k] = ~&vec[k*8 +: 8];
      byte_pos[k]  = 3'd0;
      for (int b = 7; b >= 0; b--) begin
        if (!vec[k*8 + b]) begin
          byte_pos[k] = 3'(b);
        end
      end
    end
    found = |byte_zero;
    idx   = 5'd0;
    for (int k = 3; k >= 0; k--) begin
      if (byte_zero[k]) begin
        idx = {2'(k), byte_pos[k]};
      end
    end
  end

endmodule

/* src/rsa_core.sv */
// Allocator core: sequencer, occupancy memory, use-count memory and full-word summary.
// Drives one first-zero finder for the word search and for the bit search.
// Depends on rsa_pkg and rsa_find_zero.
module rsa_core #(
  parameter int SLOTS      = rsa_pkg::SLOTS_DEF,
  parameter int COUNT_BITS = rsa_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rsa_pkg::FIXED_W-1:0]   fixed_count,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rsa_pkg::OP_W-1:0]      in_op,
  input  logic [rsa_pkg::SLOT_IN_W-1:0] in_slot,
  output logic                          res_valid,
  input  logic                          res_ready,
  output rsa_pkg::res_t                 res
);

  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CUR_W     = SLOT_W + 1;
  localparam int CW        = (CUR_W > 11) ? CUR_W : 11;
  localparam int WPW       = CW - 5;
  localparam int NCH       = 2 ** (WPW - 5);
  localparam int OCC_WORDS = (SLOTS + 31) / 32;
  localparam int OW        = $clog2(OCC_WORDS);
  localparam int OCC_DEPTH = 2 ** OW;
  localparam int CNT_DEPTH = 2 ** SLOT_W;
  localparam int LIM       = SLOTS / 32;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CUR,
    ST_SCAN,
    ST_WORD,
    ST_TAKE,
    ST_CNT
  } state_t;

  state_t                state, state_next;
  logic [SLOT_W-1:0]     clr, clr_next;
  rsa_pkg::op_t          op_q, op_q_next;
  logic [rsa_pkg::SLOT_IN_W-1:0] slot_q, slot_q_next;
  logic [CW-1:0]         cur_q, cur_q_next;
  logic [WPW-1:0]        rw_q, rw_q_next;
  logic [WPW-1:0]        ini_q, ini_q_next;
  logic [WPW-1:0]        p, p_next;
  logic [WPW-1:0]        end_w, end_w_next;
  logic                  phase2, phase2_next;
  logic [WPW-1:0]        w_q, w_q_next;
  logic [SLOT_W-1:0]     take_q, take_q_next;
  logic [CUR_W-1:0]      cursor, cursor_next;

  logic [rsa_pkg::WORD_BITS-1:0] occ_mem [OCC_DEPTH];
  logic [COUNT_BITS-1:0]         cnt_mem [CNT_DEPTH];
  logic [rsa_pkg::WORD_BITS-1:0] occ_q;
  logic [COUNT_BITS-1:0]         count_q;
  logic [OCC_WORDS-1:0]          full_map;
  logic [NCH*32-1:0]             map_pad;

  logic                          occ_re, occ_we;
  logic [OW-1:0]                 occ_ra, occ_wa;
  logic [rsa_pkg::WORD_BITS-1:0] occ_wd;
  logic                          cnt_re, cnt_we;
  logic [SLOT_W-1:0]             cnt_ra, cnt_wa;
  logic [COUNT_BITS-1:0]         cnt_wd;
  logic                          map_we, map_wd;
  logic [OW-1:0]                 map_wa;

  logic [WPW-1:0]                rw_c;
  logic [CW-1:0]                 bnd_c, cur_c;
  logic [31:0]                   chunk_bits, scan_vec, fz_vec;
  logic [WPW-1:0]                wj;
  logic                          fz_found;
  logic [4:0]                    fz_idx;
  logic                          cur_in, inr, busy, ge_bnd;
  logic [WPW-1:0]                ini_c;
  logic [COUNT_BITS-1:0]         use_val;

  rsa_find_zero u_find (
    .vec   (fz_vec),
    .found (fz_found),
    .idx   (fz_idx)
  );

  // Words past the pool read as full, so the search never lands there.
  always_comb begin
    map_pad                 = '1;
    map_pad[OCC_WORDS-1:0]  = full_map;
  end

  always_comb begin
    chunk_bits = map_pad[{p[WPW-1:5], 5'd0} +: 32];
    for (int j = 0; j < 32; j++) begin
      wj          = {p[WPW-1:5], 5'(j)};
      scan_vec[j] = chunk_bits[j] | (wj < p) | (wj >= end_w);
    end
    fz_vec = (state == ST_SCAN) ? scan_vec : occ_q;
  end

  always_comb begin
    // Reserved boundary: fixed count plus one word, rounded down to a word.
    rw_c   = WPW'({1'b0, fixed_count[9:5]} + 6'd1);
    bnd_c  = {rw_c, 5'd0};
    cur_c  = (CW'(cursor) < bnd_c) ? bnd_c : CW'(cursor);
    cur_in = cur_q < CW'(SLOTS);
    ini_c  = cur_in ? cur_q[CW-1:5] : rw_q;
    inr    = 32'(slot_q) < 32'(SLOTS);
    busy   = occ_q[slot_q[4:0]] || (slot_q < fixed_count);
    ge_bnd = CW'(slot_q) >= bnd_c;

    state_next  = state;
    clr_next    = clr;
    op_q_next   = op_q;
    slot_q_next = slot_q;
    cur_q_next  = cur_q;
    rw_q_next   = rw_q;
    ini_q_next  = ini_q;
    p_next      = p;
    end_w_next  = end_w;
    phase2_next = phase2;
    w_q_next    = w_q;
    take_q_next = take_q;
    cursor_next = cursor;

    occ_re  = 1'b0;
    occ_ra  = '0;
    occ_we  = 1'b0;
    occ_wa  = '0;
    occ_wd  = '0;
    cnt_re  = 1'b0;
    cnt_ra  = '0;
    cnt_we  = 1'b0;
    cnt_wa  = '0;
    cnt_wd  = '0;
    map_we  = 1'b0;
    map_wa  = '0;
    map_wd  = 1'b0;
    use_val = '0;

    in_ready  = (state == ST_IDLE);
    res_valid = 1'b0;
    res       = '0;

    case (state)
      ST_CLEAR: begin
        cnt_we   = 1'b1;
        cnt_wa   = clr;
        occ_we   = 32'(clr) < 32'(OCC_DEPTH);
        occ_wa   = OW'(clr);
        clr_next = clr + 1'b1;
        if (clr == '1) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          op_q_next   = rsa_pkg::op_t'(in_op);
          slot_q_next = in_slot;
          cur_q_next  = cur_c;
          rw_q_next   = rw_c;
          occ_re      = 1'b1;
          cnt_re      = 1'b1;
          cnt_ra      = SLOT_W'(in_slot);
          if (rsa_pkg::op_t'(in_op) == rsa_pkg::OP_ALLOC) begin
            occ_ra     = OW'(cur_c[CW-1:5]);
            state_next = ST_CUR;
          end else begin
            occ_ra     = OW'(in_slot[9:5]);
            state_next = ST_CNT;
          end
        end
      end

      ST_CUR: begin
        if (cur_in && !occ_q[cur_q[4:0]]) begin
          take_q_next = SLOT_W'(cur_q);
          state_next  = ST_TAKE;
        end else begin
          p_next      = ini_c;
          ini_q_next  = ini_c;
          end_w_next  = WPW'(LIM);
          phase2_next = 1'b0;
          state_next  = ST_SCAN;
        end
      end

      // One chunk of 32 summary bits per cycle; the search wraps once to the
      // reserved word.
      ST_SCAN: begin
        if (p >= end_w) begin
          if (!phase2 && (ini_q != rw_q)) begin
            p_next      = rw_q;
            end_w_next  = ini_q;
            phase2_next = 1'b1;
          end else begin
            res_valid    = 1'b1;
            res.full_res = 1'b1;
            if (res_ready) begin
              cursor_next = CUR_W'(SLOTS);
              state_next  = ST_IDLE;
            end
          end
        end else if (fz_found) begin
          w_q_next   = {p[WPW-1:5], fz_idx};
          occ_re     = 1'b1;
          occ_ra     = OW'({p[WPW-1:5], fz_idx});
          state_next = ST_WORD;
        end else begin
          p_next = {p[WPW-1:5] + 1'b1, 5'd0};
        end
      end

      ST_WORD: begin
        take_q_next = SLOT_W'({w_q, fz_idx});
        state_next  = ST_TAKE;
      end

      ST_TAKE: begin
        res_valid    = 1'b1;
        res.slot_out = rsa_pkg::SLOT_IN_W'(take_q);
        occ_wa       = OW'(take_q[SLOT_W-1:5]);
        occ_wd       = occ_q | (32'd1 << take_q[4:0]);
        map_wa       = occ_wa;
        map_wd       = &occ_wd;
        cnt_wa       = take_q;
        if (res_ready) begin
          occ_we      = 1'b1;
          map_we      = 1'b1;
          cnt_we      = 1'b1;
          cursor_next = CUR_W'(take_q) + CUR_W'(1);
          state_next  = ST_IDLE;
        end
      end

      ST_CNT: begin
        res_valid    = 1'b1;
        res.slot_out = slot_q;
        cnt_wa       = SLOT_W'(slot_q);
        occ_wa       = OW'(slot_q[9:5]);
        occ_wd       = occ_q & ~(32'd1 << slot_q[4:0]);
        map_wa       = occ_wa;
        case (op_q)
          rsa_pkg::OP_USE: begin
            if (inr) begin
              cnt_wd  = (count_q == CNT_MAX) ? count_q : count_q + 1'b1;
              cnt_we  = res_ready;
              use_val = cnt_wd;
            end
          end
          rsa_pkg::OP_DISCARD: begin
            if (!inr || !busy || (count_q == '0)) begin
              res.ignored = 1'b1;
              use_val     = inr ? count_q : '0;
            end else begin
              cnt_wd  = count_q - 1'b1;
              cnt_we  = res_ready;
              use_val = cnt_wd;
              // Slots below the boundary keep their bit even at count zero.
              if ((cnt_wd == '0) && ge_bnd) begin
                res.freed = 1'b1;
                occ_we    = res_ready;
                map_we    = res_ready;
              end
            end
          end
          default: begin
            use_val = inr ? count_q : '0;
          end
        endcase
        res.use_count = rsa_pkg::COUNT_OUT_W'(use_val);
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      clr    <= '0;
      cursor <= '0;
    end else begin
      state  <= state_next;
      clr    <= clr_next;
      cursor <= cursor_next;
    end
    op_q   <= op_q_next;
    slot_q <= slot_q_next;
    cur_q  <= cur_q_next;
    rw_q   <= rw_q_next;
    ini_q  <= ini_q_next;
    p      <= p_next;
    end_w  <= end_w_next;
    phase2 <= phase2_next;
    w_q    <= w_q_next;
    take_q <= take_q_next;
  end

  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[occ_wa] <= occ_wd;
    end
    if (occ_re) begin
      occ_q <= occ_mem[occ_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cnt_re) begin
      count_q <= cnt_mem[cnt_ra];
    end
  end

  // One bit per occupancy word: set when every slot of the stored word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      full_map <= '0;
    end else if (map_we) begin
      full_map[map_wa] <= map_wd;
    end
  end

endmodule

/* src/refcounted_slot_allocator.sv */
// Top level of the reference-counted slot allocator: configuration register,
// result register and the allocator core.
// Depends on rsa_pkg and rsa_core.
//
//   Channel   Signals                                          Direction
//   cfg       cfg_valid, cfg_ready, cfg_data                   in (fixed count)
//   in        in_valid, in_ready, op, slot                     in
//   out       out_valid, out_ready, slot_out, full_res,        out
//             freed, ignored, use_count_out
//
// Use, discard and peek are accepted with the memory reads, then written back. Allocate
// at a free cursor slot is accepted, checked at the cursor and then taken. A search
// scans the summary in chunks of 32 summary bits, ends each pass, and reads the
// occupancy word of the slot it finds. After reset a clearing pass over the count and
// occupancy memories runs before the first input beat. A result beat waiting in the
// output register stalls the core.
module refcounted_slot_allocator #(
  parameter int SLOTS      = rsa_pkg::SLOTS_DEF,
  parameter int COUNT_BITS = rsa_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rsa_pkg::FIXED_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rsa_pkg::OP_W-1:0]        op,
  input  logic [rsa_pkg::SLOT_IN_W-1:0]   slot,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rsa_pkg::SLOT_IN_W-1:0]   slot_out,
  output logic                            full_res,
  output logic                            freed,
  output logic                            ignored,
  output logic [rsa_pkg::COUNT_OUT_W-1:0] use_count_out
);

  logic [rsa_pkg::FIXED_W-1:0] fixed_count;
  logic                        res_valid, res_ready;
  rsa_pkg::res_t               res;

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_count <= '0;
    end else if (cfg_valid) begin
      fixed_count <= cfg_data;
    end
  end

  rsa_core #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .fixed_count (fixed_count),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (op),
    .in_slot     (slot),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      slot_out      <= res.slot_out;
      full_res      <= res.full_res;
      freed         <= res.freed;
      ignored       <= res.ignored;
      use_count_out <= res.use_count;
    end
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// Testbench for refcounted_slot_allocator: allocate, use, discard and peek beats
// are checked field by field against a predictor kept inside this module.
// Depends on rsa_pkg and the refcounted_slot_allocator RTL.
module tb;

  localparam int NSLOTS = rsa_pkg::SLOTS_DEF;
  localparam int NWORDS = NSLOTS / rsa_pkg::WORD_BITS;
  localparam int COUNT_TOP = (1 << rsa_pkg::COUNT_BITS_DEF) - 1;
  localparam int DRAIN_CYCLES = 16;
  localparam int ITEMS_PER_SETTING = 290;
  localparam int COUNT_RUN = 60;

  logic                            clk;
  logic                            rst;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [rsa_pkg::FIXED_W-1:0]     cfg_data;
  logic                            in_valid;
  logic                            in_ready;
  logic [rsa_pkg::OP_W-1:0]        op;
  logic [rsa_pkg::SLOT_IN_W-1:0]   slot;
  logic                            out_valid;
  logic                            out_ready;
  logic [rsa_pkg::SLOT_IN_W-1:0]   slot_out;
  logic                            full_res;
  logic                            freed;
  logic                            ignored;
  logic [rsa_pkg::COUNT_OUT_W-1:0] use_count_out;

  // Predicted allocator state.
  logic [rsa_pkg::WORD_BITS-1:0]   occ_bits [NWORDS];
  logic [rsa_pkg::COUNT_OUT_W-1:0] use_cnt [NSLOTS];
  int                              cursor = 0;
  int                              fixed_cnt = 0;

  rsa_pkg::res_t expected_q [$];
  int            handed_out [$];
  int            mismatch_count = 0;
  bit            tx_pace = 1'b1;
  bit            rx_pace = 1'b1;
  int            hold_cycles = 0;

  refcounted_slot_allocator dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .slot          (slot),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .slot_out      (slot_out),
    .full_res      (full_res),
    .freed         (freed),
    .ignored       (ignored),
    .use_count_out (use_count_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #25_000_000;
    $display("FAIL refcounted_slot_allocator");
    $finish;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(0, 2);
  endfunction

  // Occupancy word as the allocator sees it: permanent slots always read busy.
  function automatic logic [rsa_pkg::WORD_BITS-1:0] word_view(int w);
    logic [rsa_pkg::WORD_BITS-1:0] v;
    int base;
    v = occ_bits[w];
    base = w * rsa_pkg::WORD_BITS;
    if (fixed_cnt >= base + rsa_pkg::WORD_BITS) v = '1;
    else if (fixed_cnt > base) v = v | ((32'd1 << (fixed_cnt - base)) - 32'd1);
    return v;
  endfunction

  function automatic bit slot_taken(int s);
    logic [rsa_pkg::WORD_BITS-1:0] v;
    v = word_view(s / rsa_pkg::WORD_BITS);
    return v[s % rsa_pkg::WORD_BITS];
  endfunction

  function automatic bit first_free(int from, int upto, output int found);
    logic [rsa_pkg::WORD_BITS-1:0] v;
    found = 0;
    for (int w = from; w < upto; w++) begin
      v = word_view(w);
      if (v != '1) begin
        for (int b = rsa_pkg::WORD_BITS - 1; b >= 0; b--)
          if (!v[b]) found = w * rsa_pkg::WORD_BITS + b;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic rsa_pkg::res_t predict_result(rsa_pkg::op_t o,
                                                   logic [rsa_pkg::SLOT_IN_W-1:0] s);
    rsa_pkg::res_t r;
    int boundary, start, resv_word, first_word, pick;
    bit ok;
    r = '0;
    r.slot_out = s;
    boundary = (fixed_cnt + rsa_pkg::WORD_BITS) & ~(rsa_pkg::WORD_BITS - 1);
    case (o)
      rsa_pkg::OP_ALLOC: begin
        start = (cursor < boundary) ? boundary : cursor;
        resv_word = boundary / rsa_pkg::WORD_BITS;
        pick = 0;
        ok = 1'b0;
        if (start < NSLOTS && !slot_taken(start)) begin
          pick = start;
          ok = 1'b1;
        end else begin
          // Scan from the cursor word to the end, then wrap to the reserved word.
          first_word = (start < NSLOTS) ? start / rsa_pkg::WORD_BITS : resv_word;
          ok = first_free(first_word, NWORDS, pick);
          if (!ok && first_word != resv_word) ok = first_free(resv_word, first_word, pick);
        end
        if (ok) begin
          occ_bits[pick / rsa_pkg::WORD_BITS][pick % rsa_pkg::WORD_BITS] = 1'b1;
          use_cnt[pick] = '0;
          cursor = pick + 1;
          r.slot_out = pick[rsa_pkg::SLOT_IN_W-1:0];
        end else begin
          cursor = NSLOTS;
          r.slot_out = '0;
          r.full_res = 1'b1;
        end
      end
      rsa_pkg::OP_USE: begin
        if (use_cnt[s] != COUNT_TOP[rsa_pkg::COUNT_OUT_W-1:0])
          use_cnt[s] = use_cnt[s] + 1'b1;
        r.use_count = use_cnt[s];
      end
      rsa_pkg::OP_DISCARD: begin
        if (!slot_taken(s) || use_cnt[s] == '0) begin
          r.ignored = 1'b1;
          r.use_count = use_cnt[s];
        end else begin
          use_cnt[s] = use_cnt[s] - 1'b1;
          r.use_count = use_cnt[s];
          if (use_cnt[s] == '0 && s >= boundary) begin
            occ_bits[s / rsa_pkg::WORD_BITS][s % rsa_pkg::WORD_BITS] = 1'b0;
            r.freed = 1'b1;
          end
        end
      end
      default: r.use_count = use_cnt[s];
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // Offers one beat, holds it until accepted, then records the prediction.
  task automatic send_item(input rsa_pkg::op_t o, input logic [rsa_pkg::SLOT_IN_W-1:0] s,
                           output rsa_pkg::res_t r);
    int gap;
    int idx [$];
    gap = tx_pace ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    slot <= s;
    do @(posedge clk); while (!in_ready);
    r = predict_result(o, s);
    expected_q.push_back(r);
    if (o == rsa_pkg::OP_ALLOC && !r.full_res) handed_out.push_back(r.slot_out);
    if (r.freed) begin
      idx = handed_out.find_first_index(item) with (item == s);
      if (idx.size() != 0) handed_out.delete(idx[0]);
    end
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_fixed(input logic [rsa_pkg::FIXED_W-1:0] v);
    wait_results();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    fixed_cnt = v;
  endtask

  // Mostly use and discard on handed-out slots so counts return to zero and
  // slots get freed; the rest is noise on arbitrary slots.
  task automatic send_random_item();
    int roll;
    logic [rsa_pkg::SLOT_IN_W-1:0] s;
    rsa_pkg::op_t o;
    rsa_pkg::res_t r;
    roll = $urandom_range(0, 99);
    s = $urandom_range(0, NSLOTS - 1);
    if (handed_out.size() != 0 && roll >= 25 && roll < 85)
      s = handed_out[$urandom_range(0, handed_out.size() - 1)];
    if (roll < 25) o = rsa_pkg::OP_ALLOC;
    else if (roll < 55 || (roll >= 90 && roll < 95)) o = rsa_pkg::OP_USE;
    else if (roll < 85 || roll >= 95) o = rsa_pkg::OP_DISCARD;
    else o = rsa_pkg::OP_PEEK;
    send_item(o, s, r);
  endtask

  task automatic test_directed_cases();
    rsa_pkg::res_t r;
    logic [rsa_pkg::SLOT_IN_W-1:0] a;
    write_fixed(10'd40);
    send_item(rsa_pkg::OP_ALLOC, '1, r);
    a = r.slot_out;
    send_item(rsa_pkg::OP_USE, a, r);
    send_item(rsa_pkg::OP_USE, a, r);
    send_item(rsa_pkg::OP_DISCARD, a, r);
    send_item(rsa_pkg::OP_DISCARD, a, r);
    // Now free with a zero count, so the next discard is dropped.
    send_item(rsa_pkg::OP_DISCARD, a, r);
    send_item(rsa_pkg::OP_USE, a, r);
    send_item(rsa_pkg::OP_PEEK, a, r);
    send_item(rsa_pkg::OP_ALLOC, '0, r);
    send_item(rsa_pkg::OP_USE, 10'd10, r);
    send_item(rsa_pkg::OP_DISCARD, 10'd10, r);
    send_item(rsa_pkg::OP_DISCARD, 10'd10, r);
    send_item(rsa_pkg::OP_USE, 10'd50, r);
    send_item(rsa_pkg::OP_DISCARD, 10'd50, r);
    send_item(rsa_pkg::OP_USE, '0, r);
    send_item(rsa_pkg::OP_DISCARD, '0, r);
    send_item(rsa_pkg::OP_USE, '1, r);
    send_item(rsa_pkg::OP_DISCARD, '1, r);
    send_item(rsa_pkg::OP_PEEK, '1, r);
    send_item(rsa_pkg::OP_PEEK, '0, r);
    send_item(rsa_pkg::OP_ALLOC, '0, r);
    wait_results();
  endtask

  task automatic test_output_stall();
    tx_pace = 1'b0;
    rx_pace = 1'b0;
    hold_cycles = 300;
    repeat (40) send_random_item();
    wait_results();
    tx_pace = 1'b1;
    rx_pace = 1'b1;
    repeat (30) send_random_item();
    wait_results();
  endtask

  // Raises one slot's count, then lowers it past zero so it is freed and the
  // last discard is dropped.
  task automatic test_count_run();
    rsa_pkg::res_t r;
    logic [rsa_pkg::SLOT_IN_W-1:0] target;
    tx_pace = 1'b0;
    rx_pace = 1'b0;
    send_item(rsa_pkg::OP_ALLOC, '0, r);
    target = r.slot_out;
    repeat (COUNT_RUN) send_item(rsa_pkg::OP_USE, target, r);
    repeat (COUNT_RUN + 1) send_item(rsa_pkg::OP_DISCARD, target, r);
    wait_results();
    tx_pace = 1'b1;
    rx_pace = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [rsa_pkg::FIXED_W-1:0] settings [5];
    settings = '{10'd991, 10'd37, 10'd960, 10'd0, 10'd0};
    settings[4] = $urandom_range(1, 990);
    foreach (settings[p]) begin
      write_fixed(settings[p]);
      for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
        if (i % 50 == 0) begin
          tx_pace = $urandom_range(0, 3) != 0;
          rx_pace = $urandom_range(0, 3) != 0;
        end
        send_random_item();
      end
    end
    wait_results();
  endtask

  // Result side: random stalls, plus a long hold-off on request.
  initial begin
    int n;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      n = 0;
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else if (rx_pace && $urandom_range(0, 2) == 0) begin
        n = gap_len();
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rsa_pkg::res_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        flag_mismatch($sformatf("result beat with none expected, slot_out %0d", slot_out));
      end else begin
        want = expected_q.pop_front();
        if (slot_out !== want.slot_out)
          flag_mismatch($sformatf("slot_out %0d, want %0d", slot_out, want.slot_out));
        if (full_res !== want.full_res)
          flag_mismatch($sformatf("full_res %b, want %b", full_res, want.full_res));
        if (freed !== want.freed)
          flag_mismatch($sformatf("freed %b, want %b (slot %0d)", freed, want.freed,
                                  want.slot_out));
        if (ignored !== want.ignored)
          flag_mismatch($sformatf("ignored %b, want %b (slot %0d)", ignored, want.ignored,
                                  want.slot_out));
        if (use_count_out !== want.use_count)
          flag_mismatch($sformatf("use_count_out %0d, want %0d (slot %0d)", use_count_out,
                                  want.use_count, want.slot_out));
      end
    end
  end

  initial begin
    foreach (occ_bits[w]) occ_bits[w] = '0;
    foreach (use_cnt[s]) use_cnt[s] = '0;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    op <= rsa_pkg::OP_ALLOC;
    slot <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_output_stall();
    test_count_run();
    test_random_traffic();
    wait_results();
    if (mismatch_count == 0) begin
      $display("PASS refcounted_slot_allocator");
    end else begin
      $display("FAIL refcounted_slot_allocator");
    end
    $finish;
  end

endmodule
